### design/boid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package boid_pkg;
    localparam int MaxBoidsDefault = 256;
    localparam int CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] REG_BOID_COUNT = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_NEIGHBOR_DIST = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_SEPARATION_DIST = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_SEP_GAIN = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_ALIGN_GAIN = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_COH_GAIN = 3'd5;
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic wr;
        logic start;
        logic walk;
        logic latch_me;
        logic div_start;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic walk_done;
        logic div_done;
    } t_status;
endpackage
`default_nettype wire

### design/boid_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module boid_datapath #(
    parameter int MAX_BOIDS = boid_pkg::MaxBoidsDefault
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  boid_pkg::t_cmd   i_cmd,
    output boid_pkg::t_status o_status,
    input  wire [7:0]        i_boid_index,
    input  wire [15:0]       i_pos_x,
    input  wire [15:0]       i_pos_y,
    input  wire [15:0]       i_vel_x,
    input  wire [15:0]       i_vel_y,
    input  wire [8:0]        i_boid_count,
    input  wire [14:0]       i_neighbor_dist,
    input  wire [14:0]       i_separation_dist,
    input  wire [15:0]       i_sep_gain,
    input  wire [15:0]       i_align_gain,
    input  wire [15:0]       i_coh_gain,
    output logic [15:0]      o_sep_x,
    output logic [15:0]      o_sep_y,
    output logic [15:0]      o_align_x,
    output logic [15:0]      o_align_y,
    output logic [15:0]      o_coh_x,
    output logic [15:0]      o_coh_y,
    output logic [7:0]       o_neighbor_count
);
    localparam int AW = $clog2(MAX_BOIDS);
    localparam int CW = $clog2(MAX_BOIDS + 1);
    localparam int SW = 16 + CW + 1;
    localparam logic [CW-1:0] MaxCnt = CW'(MAX_BOIDS);

    logic [63:0] r_mem [MAX_BOIDS];
    logic [63:0] r_rd;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] r_addr, r_walk, n_walk;
    logic r_rd_v, r_stage_v;
    logic signed [15:0] r_mx, r_my, r_mvx, r_mvy;
    logic signed [16:0] r_dx, r_dy;
    logic signed [15:0] r_bvx, r_bvy, r_bpx, r_bpy;
    logic [33:0] r_dx2, r_dy2;
    logic signed [15:0] r_svx, r_svy, r_spx, r_spy;
    logic signed [16:0] r_sdx, r_sdy;
    logic r_sq_v;
    logic [29:0] r_rn2, r_rs2;
    logic [CW-1:0] r_cnt_n, r_cnt_s;
    logic signed [SW-1:0] r_ssx, r_ssy, r_vsx, r_vsy, r_psx, r_psy;
    logic [1:0] r_pipe_cnt;
    logic [34:0] d2;
    logic in_me;

    assign in_me = (32'(i_boid_index) < MAX_BOIDS);
    assign rd_addr = i_cmd.latch_me ? AW'(i_boid_index) : r_addr[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && in_me) begin
            r_mem[AW'(i_boid_index)] <= {i_pos_x, i_pos_y, i_vel_x, i_vel_y};
        end
        r_rd <= r_mem[rd_addr];
    end

    assign n_walk = (32'(i_boid_count) > MAX_BOIDS) ? MaxCnt : CW'(i_boid_count);
    assign d2 = 35'(r_dx2) + 35'(r_dy2);

    logic r_me_pend, r_me_ok;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
            r_stage_v <= 1'b0;
            r_sq_v <= 1'b0;
            r_me_pend <= 1'b0;
            r_pipe_cnt <= '0;
        end else begin
            r_me_pend <= i_cmd.latch_me;
            r_rd_v <= i_cmd.walk && (r_addr < r_walk);
            r_stage_v <= r_rd_v;
            r_sq_v <= r_stage_v;
            if (i_cmd.walk && r_addr >= r_walk && r_pipe_cnt != 2'd3) begin
                r_pipe_cnt <= r_pipe_cnt + 2'd1;
            end else if (!i_cmd.walk) begin
                r_pipe_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_me) begin
            r_me_ok <= in_me;
            r_addr <= '0;
            r_walk <= n_walk;
            r_rn2 <= i_neighbor_dist * i_neighbor_dist;
            r_rs2 <= i_separation_dist * i_separation_dist;
        end else if (i_cmd.walk && r_addr < r_walk) begin
            r_addr <= r_addr + 1'b1;
        end
        if (r_me_pend) begin
            r_mx <= r_me_ok ? r_rd[63:48] : '0;
            r_my <= r_me_ok ? r_rd[47:32] : '0;
            r_mvx <= r_me_ok ? r_rd[31:16] : '0;
            r_mvy <= r_me_ok ? r_rd[15:0] : '0;
        end
        r_dx <= 17'(signed'(r_rd[63:48])) - 17'(r_mx);
        r_dy <= 17'(signed'(r_rd[47:32])) - 17'(r_my);
        r_bpx <= r_rd[63:48];
        r_bpy <= r_rd[47:32];
        r_bvx <= r_rd[31:16];
        r_bvy <= r_rd[15:0];
        r_dx2 <= 34'(r_dx * r_dx);
        r_dy2 <= 34'(r_dy * r_dy);
        r_sdx <= r_dx;
        r_sdy <= r_dy;
        r_spx <= r_bpx;
        r_spy <= r_bpy;
        r_svx <= r_bvx;
        r_svy <= r_bvy;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_me) begin
            r_cnt_n <= '0;
            r_cnt_s <= '0;
            r_ssx <= '0;
            r_ssy <= '0;
            r_vsx <= '0;
            r_vsy <= '0;
            r_psx <= '0;
            r_psy <= '0;
        end else if (r_sq_v && d2 != '0) begin
            if (d2 < 35'(r_rs2)) begin
                r_cnt_s <= r_cnt_s + 1'b1;
                r_ssx <= r_ssx + SW'(r_sdx);
                r_ssy <= r_ssy + SW'(r_sdy);
            end
            if (d2 < 35'(r_rn2)) begin
                r_cnt_n <= r_cnt_n + 1'b1;
                r_vsx <= r_vsx + SW'(r_svx);
                r_vsy <= r_vsy + SW'(r_svy);
                r_psx <= r_psx + SW'(r_spx);
                r_psy <= r_psy + SW'(r_spy);
            end
        end
    end

    assign o_status.walk_done = (r_pipe_cnt == 2'd3);

    // Four sums are divided one after another by a shared restoring divider.
    localparam int QW = SW;
    localparam int DW = $clog2(QW + 2);
    localparam logic [DW-1:0] DivShiftLast = DW'(QW);
    localparam logic [DW-1:0] DivLast = DW'(QW + 1);
    logic [1:0] r_dsel;
    logic r_dbusy;
    logic [DW-1:0] r_dstep;
    logic [QW-1:0] r_rem_q;
    logic [CW:0] r_rem;
    logic r_dneg;
    logic signed [16:0] r_mean [4];
    logic signed [SW-1:0] dsrc;
    logic [QW-1:0] dabs;
    logic [CW:0] trial;
    logic signed [SW:0] qsg;

    always_comb begin
        case (r_dsel)
            2'd0: dsrc = r_vsx;
            2'd1: dsrc = r_vsy;
            2'd2: dsrc = r_psx;
            default: dsrc = r_psy;
        endcase
    end
    assign dabs = dsrc[SW-1] ? QW'(-dsrc) : QW'(dsrc);
    assign trial = {r_rem[CW-1:0], r_rem_q[QW-1]};
    assign qsg = r_dneg ? -(SW+1)'(r_rem_q) : (SW+1)'(r_rem_q);

    logic r_ddone;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_ddone <= 1'b0;
            r_dsel <= '0;
            r_dstep <= '0;
        end else begin
            r_ddone <= 1'b0;
            if (i_cmd.div_start) begin
                r_dbusy <= 1'b1;
                r_dsel <= '0;
                r_dstep <= '0;
            end else if (r_dbusy) begin
                if (r_dstep == DivLast) begin
                    r_dstep <= '0;
                    if (r_dsel == 2'd3) begin
                        r_dbusy <= 1'b0;
                        r_ddone <= 1'b1;
                    end
                    r_dsel <= r_dsel + 2'd1;
                end else begin
                    r_dstep <= r_dstep + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_dbusy) begin
            if (r_dstep == '0) begin
                r_rem_q <= dabs;
                r_rem <= '0;
                r_dneg <= dsrc[SW-1];
            end else if (r_dstep <= DivShiftLast) begin
                if (trial >= (CW+1)'(r_cnt_n)) begin
                    r_rem <= trial - (CW+1)'(r_cnt_n);
                    r_rem_q <= {r_rem_q[QW-2:0], 1'b1};
                end else begin
                    r_rem <= trial;
                    r_rem_q <= {r_rem_q[QW-2:0], 1'b0};
                end
            end
            if (r_dstep == DivLast) begin
                r_mean[r_dsel] <= 17'(qsg);
            end
        end
    end
    assign o_status.div_done = r_ddone;

    function automatic logic [15:0] gain_apply(input logic [15:0] g,
                                               input logic signed [SW-1:0] x,
                                               input logic neg);
        logic signed [SW+16:0] p;
        logic signed [SW:0] t;
        p = $signed({1'b0, g}) * x;
        t = neg ? -(SW+1)'(p >>> 16) : (SW+1)'(p >>> 16);
        if (t > (SW+1)'(32767)) begin
            return 16'h7fff;
        end else if (t < -(SW+1)'(32768)) begin
            return 16'h8000;
        end
        return t[15:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_sep_x <= (r_cnt_s != '0) ? gain_apply(i_sep_gain, r_ssx, 1'b1) : '0;
            o_sep_y <= (r_cnt_s != '0) ? gain_apply(i_sep_gain, r_ssy, 1'b1) : '0;
            o_align_x <= (r_cnt_n != '0) ?
                gain_apply(i_align_gain, SW'(r_mean[0]) - SW'(r_mvx), 1'b0) : '0;
            o_align_y <= (r_cnt_n != '0) ?
                gain_apply(i_align_gain, SW'(r_mean[1]) - SW'(r_mvy), 1'b0) : '0;
            o_coh_x <= (r_cnt_n != '0) ?
                gain_apply(i_coh_gain, SW'(r_mean[2]) - SW'(r_mx), 1'b0) : '0;
            o_coh_y <= (r_cnt_n != '0) ?
                gain_apply(i_coh_gain, SW'(r_mean[3]) - SW'(r_my), 1'b0) : '0;
            o_neighbor_count <= (r_cnt_n > CW'(255)) ? 8'd255 : 8'(r_cnt_n);
        end
    end
endmodule
`default_nettype wire

### design/boid_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module boid_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  wire               i_opcode,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output boid_pkg::t_cmd    o_cmd,
    input  boid_pkg::t_status i_status
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_WALK = 5'b00010,
        S_DIV  = 5'b00100,
        S_FIN  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic acc;

    assign o_in_stall = (r_state != S_IDLE);
    assign acc = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    o_cmd.wr = (i_opcode == boid_pkg::OP_WRITE);
                    if (i_opcode == boid_pkg::OP_QUERY) begin
                        o_cmd.latch_me = 1'b1;
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_status.walk_done) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && i_out_stall) |=> (r_state == S_OUT))
        else $error("result word dropped while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> o_out_valid)
        else $error("finish did not present a result");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_opcode == boid_pkg::OP_WRITE) |=> (r_state == S_IDLE))
        else $error("write left the idle state");
endmodule
`default_nettype wire

### design/boid_steering_forces.sv
`timescale 1ns / 1ps
`default_nettype none
// A write word is accepted while idle and yields no result.
// A query walks min(boid_count, MAX_BOIDS) entries through one read port,
// divides four sums, and then registers the forces as its result.
// One word is in work at a time. Reset is synchronous, active low; it sets the
// control and configuration registers to their defaults and leaves the boid
// table contents undefined.
module boid_steering_forces #(
    parameter int MAX_BOIDS = boid_pkg::MaxBoidsDefault
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  wire        i_opcode,
    input  wire [7:0]  i_boid_index,
    input  wire [15:0] i_pos_x,
    input  wire [15:0] i_pos_y,
    input  wire [15:0] i_vel_x,
    input  wire [15:0] i_vel_y,
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output logic [15:0] o_sep_x,
    output logic [15:0] o_sep_y,
    output logic [15:0] o_align_x,
    output logic [15:0] o_align_y,
    output logic [15:0] o_coh_x,
    output logic [15:0] o_coh_y,
    output logic [7:0] o_neighbor_count,
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire [boid_pkg::CfgIdxW-1:0] i_cfg_index,
    input  wire [15:0] i_cfg_data
);
    logic [8:0] r_boid_count;
    logic [14:0] r_neighbor_dist, r_separation_dist;
    logic [15:0] r_sep_gain, r_align_gain, r_coh_gain;
    boid_pkg::t_cmd cmd;
    boid_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boid_count <= '0;
            r_neighbor_dist <= 15'd1600;
            r_separation_dist <= 15'd320;
            r_sep_gain <= 16'd6554;
            r_align_gain <= 16'd6554;
            r_coh_gain <= 16'd6554;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                boid_pkg::REG_BOID_COUNT: r_boid_count <= i_cfg_data[8:0];
                boid_pkg::REG_NEIGHBOR_DIST: r_neighbor_dist <= i_cfg_data[14:0];
                boid_pkg::REG_SEPARATION_DIST: r_separation_dist <= i_cfg_data[14:0];
                boid_pkg::REG_SEP_GAIN: r_sep_gain <= i_cfg_data;
                boid_pkg::REG_ALIGN_GAIN: r_align_gain <= i_cfg_data;
                boid_pkg::REG_COH_GAIN: r_coh_gain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    boid_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_opcode(i_opcode),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_cmd(cmd), .i_status(status)
    );

    boid_datapath #(.MAX_BOIDS(MAX_BOIDS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_status(status),
        .i_boid_index(i_boid_index), .i_pos_x(i_pos_x), .i_pos_y(i_pos_y),
        .i_vel_x(i_vel_x), .i_vel_y(i_vel_y),
        .i_boid_count(r_boid_count), .i_neighbor_dist(r_neighbor_dist),
        .i_separation_dist(r_separation_dist), .i_sep_gain(r_sep_gain),
        .i_align_gain(r_align_gain), .i_coh_gain(r_coh_gain),
        .o_sep_x(o_sep_x), .o_sep_y(o_sep_y), .o_align_x(o_align_x),
        .o_align_y(o_align_y), .o_coh_x(o_coh_x), .o_coh_y(o_coh_y),
        .o_neighbor_count(o_neighbor_count)
    );
endmodule
`default_nettype wire
